// ----- sv/fun8_pkg.sv -----
// package: payload types, operation codes and the byte-to-float conversion
package fun8_pkg;

    typedef enum logic [1:0] {
        OP_BYTE_TO_F32 = 2'd0,
        OP_F32_TO_BYTE = 2'd1,
        OP_F64_TO_F32  = 2'd2,
        OP_NONE        = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] value;
        logic        last_item;
    } t_in_word;

    typedef struct packed {
        logic [31:0] conv_bits;
        logic        admitted;
        logic        last;
    } t_out_word;

    localparam logic [31:0] F32_ONE   = 32'h3f800000;
    localparam logic [31:0] F32_NZERO = 32'h80000000;
    localparam logic [31:0] F32_INF   = 32'h7f800000;
    localparam logic [10:0] EXP_MIN64 = 11'd897;
    localparam logic [10:0] EXP_MAX64 = 11'd2047;
    localparam logic [10:0] EXP_BIAS_DIFF = 11'd896;

    // c/255 rounded to nearest even, as binary32 bits
    // c/255 is the byte c repeated forever after the binary point, so the
    // tail below the kept bits is never exactly half and its top bit rounds
    function automatic logic [31:0] byte_to_f32(input logic [7:0] c);
        logic [2:0]  lz;
        logic [39:0] pat;
        logic [24:0] m;
        logic [7:0]  ex;
        begin
            lz = 3'd0;
            for (int k = 0; k < 8; k++) begin
                if (c[k]) begin
                    lz = 3'(7 - k);
                end
            end
            pat = {c, c, c, c, c} << lz;
            m = {1'b0, pat[39:16]} + {24'd0, pat[15]};
            ex = 8'd126 - {5'd0, lz};
            // mantissa carry out: all ones rounded up to the next power of two
            if (m[24]) begin
                ex = ex + 8'd1;
            end
            if (c == 8'd0) begin
                byte_to_f32 = 32'd0;
            end else begin
                byte_to_f32 = {1'b0, ex, m[22:0]};
            end
        end
    endfunction

endpackage

// ----- sv/float_unorm8_narrow_converter.sv -----
// top level: byte / binary32 / binary64 conversion pipeline
// pipeline: three register stages (decode and classify, multiply, round and select)
// throughput: one word per cycle while the output is not stalled, through the three-stage conversion pipeline
// a stall on the output freezes the whole pipeline; nothing is lost or repeated
// reset: synchronous active-low reset clears the stage valid bits only
module float_unorm8_narrow_converter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fun8_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fun8_pkg::t_out_word  o_data
);

    // pipeline advances whenever the output slot is empty or being taken
    logic w_en;
    assign w_en = i_ready || !o_valid;
    assign o_ready = w_en;

    fun8_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_word  (i_data),
        .o_valid (o_valid),
        .o_word  (o_data)
    );

endmodule

// ----- sv/fun8_core.sv -----
// conversion datapath: three register stages with valid bits and stall
module fun8_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  fun8_pkg::t_in_word   i_word,
    output logic                 o_valid,
    output fun8_pkg::t_out_word  o_word
);

    // stage 1: decode and classify
    logic        r_v1;
    logic [1:0]  r_op1;
    logic        r_last1;
    logic [31:0] r_b2f1;
    logic        r_s2b_zero1;
    logic        r_s2b_ok1;
    logic [23:0] r_sig1;
    logic [7:0]  r_sh1;
    logic        r_d_ok1;
    logic        r_d_sign1;
    logic [10:0] r_d_ex1;
    logic [23:0] r_d_m1;
    logic [28:0] r_d_rem1;

    // stage 2: multiply and round pieces
    logic        r_v2;
    logic [1:0]  r_op2;
    logic        r_last2;
    logic [31:0] r_b2f2;
    logic        r_s2b_zero2;
    logic        r_s2b_ok2;
    logic [31:0] r_p2;
    logic [7:0]  r_sh2;
    logic        r_d_ok2;
    logic [31:0] r_d_comb2;

    logic [31:0] n_sig_word;
    logic [7:0]  n_ex;
    logic [23:0] n_sig;
    logic [23:0] n_d_m;
    logic [33:0] n_d_comb;

    always_comb begin
        n_sig_word = i_word.value[31:0];
        n_ex = n_sig_word[30:23];
        n_sig = {1'b0, n_sig_word[22:0]};
        if (n_ex != 8'd0) begin
            n_sig[23] = 1'b1;
        end else begin
            n_ex = 8'd1;
        end
    end

    // wide enough that an exponent past the binary32 range still shows
    always_comb begin
        n_d_m = r_d_m1;
        if ((r_d_rem1 > 29'h10000000)
            || (r_d_rem1 == 29'h10000000 && r_d_m1[0])) begin
            n_d_m = r_d_m1 + 24'd1;
        end
        n_d_comb = (34'(r_d_ex1 - fun8_pkg::EXP_BIAS_DIFF) << 23) + {10'd0, n_d_m};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op1 <= i_word.operation;
            r_last1 <= i_word.last_item;
            r_b2f1 <= fun8_pkg::byte_to_f32(i_word.value[7:0]);
            r_s2b_ok1 <= (n_sig_word == fun8_pkg::F32_NZERO)
                || (n_sig_word <= fun8_pkg::F32_ONE);
            r_sh1 <= 8'd150 - n_ex;
            r_s2b_zero1 <= (n_sig_word == fun8_pkg::F32_NZERO)
                || ((8'd150 - n_ex) > 8'd40);
            r_sig1 <= n_sig;
            r_d_ok1 <= (i_word.value[62:52] >= fun8_pkg::EXP_MIN64)
                && (i_word.value[62:52] != fun8_pkg::EXP_MAX64);
            r_d_sign1 <= i_word.value[63];
            r_d_ex1 <= i_word.value[62:52];
            r_d_m1 <= {1'b0, i_word.value[51:29]};
            r_d_rem1 <= i_word.value[28:0];

            r_op2 <= r_op1;
            r_last2 <= r_last1;
            r_b2f2 <= r_b2f1;
            r_s2b_zero2 <= r_s2b_zero1;
            r_s2b_ok2 <= r_s2b_ok1;
            r_p2 <= 32'(r_sig1) * 32'd255;
            r_sh2 <= r_sh1;
            r_d_ok2 <= r_d_ok1 && (n_d_comb[33:31] == 3'd0);
            r_d_comb2 <= {r_d_sign1, n_d_comb[30:0]};
        end
    end

    // stage 3: round the byte product, pick the result
    logic [31:0] n_q;
    logic [31:0] n_rem;
    logic [31:0] n_half;
    logic [5:0]  n_shs;
    fun8_pkg::t_out_word n_out;

    always_comb begin
        n_shs = r_sh2[5:0];
        n_q = r_p2 >> n_shs;
        n_half = 32'd1 << (n_shs - 6'd1);
        n_rem = r_p2 & ((32'd1 << n_shs) - 32'd1);
        if (n_shs >= 6'd32) begin
            n_q = 32'd0;
            n_rem = r_p2;
            n_half = (n_shs == 6'd32) ? 32'h80000000 : 32'd0;
        end
        if (n_shs > 6'd32) begin
            n_rem = 32'd0;
            n_half = 32'd1;
        end
        if (n_rem > n_half || (n_rem == n_half && n_q[0])) begin
            n_q = n_q + 32'd1;
        end
        n_out.last = r_last2;
        n_out.admitted = 1'b0;
        n_out.conv_bits = 32'd0;
        unique case (fun8_pkg::t_op'(r_op2))
            fun8_pkg::OP_BYTE_TO_F32: begin
                n_out.admitted = 1'b1;
                n_out.conv_bits = r_b2f2;
            end
            fun8_pkg::OP_F32_TO_BYTE: begin
                n_out.admitted = r_s2b_ok2;
                if (r_s2b_ok2 && !r_s2b_zero2) begin
                    n_out.conv_bits = {24'd0, n_q[7:0]};
                end
            end
            fun8_pkg::OP_F64_TO_F32: begin
                if (r_d_ok2 && {1'b0, r_d_comb2[30:0]} < fun8_pkg::F32_INF) begin
                    n_out.admitted = 1'b1;
                    n_out.conv_bits = r_d_comb2;
                end
            end
            default: begin
                n_out.admitted = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_word <= n_out;
        end
    end

endmodule
